FILE: rtl/core/strmq_pkg.sv
// strmq_pkg: shared constants, status codes and control structs for the
// sparse table range maximum core; no dependencies

package strmq_pkg;

    // array geometry
    localparam int DEPTH       = 1024;
    localparam int LEVELS      = 11;
    localparam int VALUE_WIDTH = 32;

    // fixed field widths of the stream payload
    localparam int IN_VALUE_W = 32;
    localparam int OUT_W      = 32;
    localparam int RANGE_W    = 11;
    localparam int IN_TDATA_W = 56;

    // derived widths
    localparam int TBL_DEPTH = LEVELS * DEPTH;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int POS_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int LVL_W     = $clog2(LEVELS + 1);
    localparam int WIN_W     = ((CNT_W > LEVELS) ? CNT_W : LEVELS) + 1;
    localparam int CMP_W     = (CNT_W > RANGE_W) ? CNT_W : RANGE_W;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_BUILT = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic update;
    } t_cmp_ctrl;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [ADDR_W-1:0]      raddr;
    } t_ram_req;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        t_status          status;
    } t_result;

endpackage

FILE: rtl/core/strmq_ram.sv
// strmq_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module strmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/strmq_cmp.sv
// strmq_cmp: shared signed maximum unit with accumulator register
// depends on strmq_pkg

module strmq_cmp
    import strmq_pkg::*;
(
    input  logic                          i_clk,
    input  t_cmp_ctrl                     i_ctrl,
    input  logic signed [VALUE_WIDTH-1:0] i_data,
    output logic signed [VALUE_WIDTH-1:0] o_acc
);

    logic signed [VALUE_WIDTH-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= i_data;
        end else if (i_ctrl.update && (i_data > r_acc)) begin
            r_acc <= i_data;
        end
    end

    assign o_acc = r_acc;

endmodule

FILE: rtl/core/strmq_seq.sv
// strmq_seq: sequencer for loads, table build and queries; drives the table
// ram and the shared max unit; depends on strmq_pkg

module strmq_seq
    import strmq_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_func,
    input  logic signed [IN_VALUE_W-1:0]  i_value,
    input  logic                          i_last,
    input  logic [RANGE_W-1:0]            i_left,
    input  logic [RANGE_W-1:0]            i_right,
    input  logic                          i_out_free,
    input  logic signed [VALUE_WIDTH-1:0] i_acc,
    output logic                          o_ready,
    output logic                          o_res_valid,
    output t_result                       o_res,
    output t_ram_req                      o_ram,
    output t_cmp_ctrl                     o_cmp
);

    localparam int KW = (LVL_W > $clog2(RANGE_W)) ? LVL_W : $clog2(RANGE_W);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_Q_A   = 10'b0000000010,
        S_Q_B   = 10'b0000000100,
        S_Q_C   = 10'b0000001000,
        S_DONE  = 10'b0000010000,
        S_B_CHK = 10'b0000100000,
        S_B_RA  = 10'b0001000000,
        S_B_RB  = 10'b0010000000,
        S_B_CB  = 10'b0100000000,
        S_B_WR  = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_built, n_built;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [POS_W-1:0]   r_pos_a, n_pos_a;
    logic [POS_W-1:0]   r_pos_b, n_pos_b;
    t_status            r_status, n_status;

    logic [CNT_W-1:0]   cnt_eff;
    logic [WIN_W-1:0]   win;
    logic [WIN_W-1:0]   half;
    logic [POS_W-1:0]   pos_half;
    logic               next_fits;
    logic               lvl_fits;
    logic [RANGE_W-1:0] len;
    logic [KW-1:0]      k_raw;
    logic [LVL_W-1:0]   q_lvl;
    logic [RANGE_W-1:0] q_win;

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [POS_W-1:0] pos);
        return ADDR_W'(lvl) * ADDR_W'(DEPTH) + ADDR_W'(pos);
    endfunction

    // build window arithmetic
    assign cnt_eff   = r_built ? '0 : r_count;
    assign win       = WIN_W'(1) << r_lvl;
    assign half      = win >> 1;
    assign pos_half  = POS_W'(WIN_W'(r_pos_a) + half);
    assign next_fits = (WIN_W'(r_pos_a) + WIN_W'(1) + win) <= WIN_W'(r_count);
    assign lvl_fits  = (r_lvl < LVL_W'(LEVELS)) && (win <= WIN_W'(r_count));

    // query level: floor log2 of the range length, clamped to the top level
    assign len = i_right - i_left + RANGE_W'(1);

    always_comb begin
        k_raw = '0;
        for (int b = 0; b < RANGE_W; b++) begin
            if (len[b]) begin
                k_raw = KW'(b);
            end
        end
    end

    assign q_lvl = (k_raw > KW'(LEVELS - 1)) ? LVL_W'(LEVELS - 1) : LVL_W'(k_raw);
    assign q_win = RANGE_W'(1) << q_lvl;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_built     = r_built;
        n_lvl       = r_lvl;
        n_pos_a     = r_pos_a;
        n_pos_b     = r_pos_b;
        n_status    = r_status;
        o_ram.we    = 1'b0;
        o_ram.waddr = '0;
        o_ram.wdata = VALUE_WIDTH'(i_value);
        o_ram.raddr = '0;
        o_cmp       = '0;
        o_res_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_accept && !i_func) begin
                    // a load after a build restarts the array
                    n_built = 1'b0;
                    n_count = cnt_eff;
                    if (cnt_eff < CNT_W'(DEPTH)) begin
                        o_ram.we    = 1'b1;
                        o_ram.waddr = tbl_addr('0, POS_W'(cnt_eff));
                        n_count     = cnt_eff + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_lvl   = LVL_W'(1);
                        n_state = S_B_CHK;
                    end
                end else if (i_accept) begin
                    n_lvl   = q_lvl;
                    n_pos_a = POS_W'(i_left - RANGE_W'(1));
                    n_pos_b = POS_W'(i_right - q_win);
                    if (!r_built) begin
                        n_status = ST_NOT_BUILT;
                        n_state  = S_DONE;
                    end else if (i_left > i_right) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else if ((i_left == '0) ||
                                 (CMP_W'(i_right) > CMP_W'(r_count))) begin
                        n_status = ST_RANGE;
                        n_state  = S_DONE;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_Q_A;
                    end
                end
            end
            S_Q_A: begin
                o_ram.raddr = tbl_addr(r_lvl, r_pos_a);
                n_state     = S_Q_B;
            end
            S_Q_B: begin
                o_ram.raddr = tbl_addr(r_lvl, r_pos_b);
                o_cmp.load  = 1'b1;
                n_state     = S_Q_C;
            end
            S_Q_C: begin
                o_cmp.update = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_B_CHK: begin
                if (lvl_fits) begin
                    n_pos_a = '0;
                    n_state = S_B_RA;
                end else begin
                    n_built = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_B_RA: begin
                o_ram.raddr = tbl_addr(r_lvl - LVL_W'(1), r_pos_a);
                n_state     = S_B_RB;
            end
            S_B_RB: begin
                o_ram.raddr = tbl_addr(r_lvl - LVL_W'(1), pos_half);
                o_cmp.load  = 1'b1;
                n_state     = S_B_CB;
            end
            S_B_CB: begin
                o_cmp.update = 1'b1;
                n_state      = S_B_WR;
            end
            S_B_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = tbl_addr(r_lvl, r_pos_a);
                o_ram.wdata = i_acc;
                if (next_fits) begin
                    n_pos_a = r_pos_a + POS_W'(1);
                    n_state = S_B_RA;
                end else begin
                    n_lvl   = r_lvl + LVL_W'(1);
                    n_state = S_B_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.status = r_status;
        case (r_status)
            ST_OK:    o_res.value = OUT_W'(i_acc);
            ST_EMPTY: o_res.value = '1;
            default:  o_res.value = '0;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_built <= n_built;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl    <= n_lvl;
        r_pos_a  <= n_pos_a;
        r_pos_b  <= n_pos_b;
        r_status <= n_status;
    end

    // the max unit only folds in a second operand right after loading the first
    a_update_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmp.update |-> $past(o_cmp.load))
        else $error("max unit update without preceding load");

    // a query never leaves the block ready in the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_func) |=> !o_ready)
        else $error("ready right after a query transfer");

    // no table write while a query reads the table
    a_no_write_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_A || r_state == S_Q_B || r_state == S_Q_C) |-> !o_ram.we)
        else $error("table write during query");

    // an ok result only comes from a built table
    a_ok_needs_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_OK) |-> r_built)
        else $error("ok status without a built table");

endmodule

FILE: rtl/core/sparse_table_range_max_core.sv
// sparse table range maximum core: load, build and range-max query over streams
// an error-status query goes from idle straight to done; a valid range reads the table in Q_A and
// Q_B, compares in Q_C, then waits in done for a free output register; a new query is taken only in
// idle. One load per cycle until the last load; then the build reads two lower-level windows and
// writes one entry per window, level by level, over the single read port; input stalls meanwhile
// reset: i_rst_n sync active low, clears count and built flag; table undefined until written

module sparse_table_range_max_core
    import strmq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transfers
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // load_value[31:0], range_left[42:32],
                                                 // range_right[53:43], zero pad[55:54]
    input  logic                  s_axis_tlast,  // load_last
    input  logic                  s_axis_tuser,  // func: 0 load, 1 query
    // result transfers
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,  // max_value[31:0]
    output logic [1:0]            m_axis_tuser   // status[1:0]
);

    logic                          in_accept;
    logic                          out_free;
    logic                          seq_ready;
    logic                          res_valid;
    t_result                       res;
    t_ram_req                      ram_req;
    t_cmp_ctrl                     cmp_ctrl;
    logic signed [VALUE_WIDTH-1:0] rdata;
    logic signed [VALUE_WIDTH-1:0] acc;

    // output register; the sequencer may finish a query while it is drained
    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;
    t_status          r_m_status;

    assign in_accept     = s_axis_tvalid && seq_ready;
    assign s_axis_tready = seq_ready;
    assign out_free      = !r_m_valid || m_axis_tready;

    strmq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_func      (s_axis_tuser),
        .i_value     (s_axis_tdata[IN_VALUE_W-1:0]),
        .i_last      (s_axis_tlast),
        .i_left      (s_axis_tdata[IN_VALUE_W +: RANGE_W]),
        .i_right     (s_axis_tdata[IN_VALUE_W + RANGE_W +: RANGE_W]),
        .i_out_free  (out_free),
        .i_acc       (acc),
        .o_ready     (seq_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram       (ram_req),
        .o_cmp       (cmp_ctrl)
    );

    // window maximum table, all levels in one memory
    strmq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    // shared signed max unit for both build and query
    strmq_cmp u_cmp (
        .i_clk  (i_clk),
        .i_ctrl (cmp_ctrl),
        .i_data (rdata),
        .o_acc  (acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_data   <= res.value;
            r_m_status <= res.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_status;

endmodule
